// File: hdl/pcc_pkg.sv
package pcc_pkg;

    // Default number of CORDIC cells
    localparam int PCC_STAGES_DEF = 18;

    // Field widths
    localparam int RAD_IN_W = 23;
    localparam int LEN_W    = 24;
    localparam int ANG_W    = 20;

    // Internal formats: lengths carry guard bits, angles carry 30 fraction bits
    localparam int GUARD     = 6;
    localparam int ANG_SHIFT = 14;
    localparam int XY_W      = LEN_W + GUARD + 3;
    localparam int Z_W       = ANG_W + ANG_SHIFT;
    localparam int K_W       = 31;
    localparam int PROD_W    = XY_W + K_W;
    localparam int ROUND_SH  = 30 + GUARD;

    localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 34'sd6746518852;

    // Output limits
    localparam int XY_MAX  = 8388607;
    localparam int XY_MIN  = -8388608;
    localparam int RAD_MAX = 16777215;
    localparam int ANG_LIM = 411775;

    // Operation codes
    localparam logic OP_TO_CART  = 1'b0;
    localparam logic OP_TO_POLAR = 1'b1;

    typedef struct packed {
        logic                        operation;
        logic [RAD_IN_W-1:0]         radius_in;
        logic signed [ANG_W-1:0]     azimuth_in;
        logic signed [LEN_W-1:0]     x_in;
        logic signed [LEN_W-1:0]     y_in;
    } t_in_word;

    typedef struct packed {
        logic signed [LEN_W-1:0]     x_out;
        logic signed [LEN_W-1:0]     y_out;
        logic [LEN_W-1:0]            radius_out;
        logic signed [ANG_W-1:0]     azimuth_out;
    } t_out_word;

    // What one cell hands to the next; p0/p1 carry the pass-through fields
    typedef struct packed {
        logic                        valid;
        logic                        op;
        logic                        zero;
        logic signed [XY_W-1:0]      x;
        logic signed [XY_W-1:0]      y;
        logic signed [Z_W-1:0]       z;
        logic [LEN_W-1:0]            p0;
        logic [LEN_W-1:0]            p1;
    } t_stage;

    // atan(2^-idx), 30 fraction bits, rounded to nearest
    function automatic logic signed [Z_W-1:0] pcc_atan(input int idx);
        case (idx)
            0:       return 34'sd843314857;
            1:       return 34'sd497837829;
            2:       return 34'sd263043837;
            3:       return 34'sd133525159;
            4:       return 34'sd67021687;
            5:       return 34'sd33543516;
            6:       return 34'sd16775851;
            7:       return 34'sd8388437;
            8:       return 34'sd4194283;
            9:       return 34'sd2097149;
            10:      return 34'sd1048576;
            default: return Z_W'(64'sd1 <<< (30 - idx));
        endcase
    endfunction

    // floor(sqrt(P)) of the accumulated CORDIC gain square, P scaled by 2^60
    function automatic logic [63:0] pcc_gain_root(input int stages);
        logic [63:0] p;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        p = 64'd1 << 60;
        for (int i = 0; i < stages; i++) begin
            p = p + (p >> (2 * i));
        end
        v = p;
        r = '0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

endpackage

// File: hdl/pcc_in_if.sv
interface pcc_in_if;
    import pcc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [RAD_IN_W-1:0]     radius_in;
    logic signed [ANG_W-1:0] azimuth_in;
    logic signed [LEN_W-1:0] x_in;
    logic signed [LEN_W-1:0] y_in;

    modport source (
        output valid, operation, radius_in, azimuth_in, x_in, y_in,
        input  ready
    );

    modport sink (
        input  valid, operation, radius_in, azimuth_in, x_in, y_in,
        output ready
    );
endinterface

// File: hdl/pcc_out_if.sv
interface pcc_out_if;
    import pcc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [LEN_W-1:0] x_out;
    logic signed [LEN_W-1:0] y_out;
    logic [LEN_W-1:0]        radius_out;
    logic signed [ANG_W-1:0] azimuth_out;

    modport source (
        output valid, x_out, y_out, radius_out, azimuth_out,
        input  ready
    );

    modport sink (
        input  valid, x_out, y_out, radius_out, azimuth_out,
        output ready
    );
endinterface

// File: hdl/pcc_prep.sv
module pcc_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_fire,
    input  pcc_pkg::t_in_word i_word,
    output pcc_pkg::t_stage   o_stage
);
    import pcc_pkg::*;

    localparam logic signed [Z_W:0] HALF_E   = (Z_W+1)'(HALF_PI_Q30);
    localparam logic signed [Z_W:0] PI_E     = (Z_W+1)'(PI_Q30);
    localparam logic signed [Z_W:0] TWO_PI_E = (Z_W+1)'(TWO_PI_Q30);

    t_stage r_stage;
    t_stage n_stage;

    logic signed [Z_W-1:0]  ang;
    logic signed [Z_W:0]    ang_e;
    logic signed [Z_W:0]    ang_off;
    logic signed [Z_W:0]    ang_sum;
    logic signed [XY_W-1:0] r_mag;
    logic signed [XY_W-1:0] x_sc;
    logic signed [XY_W-1:0] y_sc;
    logic                   wrap_dn;
    logic                   wrap_up;
    logic                   q_dn;
    logic                   q_up;

    assign ang   = {i_word.azimuth_in, {ANG_SHIFT{1'b0}}};
    assign ang_e = (Z_W+1)'(ang);
    assign r_mag = XY_W'({i_word.radius_in, {GUARD{1'b0}}});
    assign x_sc  = {{(XY_W-LEN_W-GUARD){i_word.x_in[LEN_W-1]}}, i_word.x_in, {GUARD{1'b0}}};
    assign y_sc  = {{(XY_W-LEN_W-GUARD){i_word.y_in[LEN_W-1]}}, i_word.y_in, {GUARD{1'b0}}};

    // Wrap into [-pi, pi] and fold into [-pi/2, pi/2], all compares on the raw angle
    always_comb begin
        wrap_dn = ang_e > PI_E;
        wrap_up = ang_e < -PI_E;
        if (wrap_dn) begin
            q_dn = ang_e > (HALF_E + TWO_PI_E);
            q_up = ang_e < (TWO_PI_E - HALF_E);
        end else if (wrap_up) begin
            q_dn = ang_e > (HALF_E - TWO_PI_E);
            q_up = ang_e < (-HALF_E - TWO_PI_E);
        end else begin
            q_dn = ang_e > HALF_E;
            q_up = ang_e < -HALF_E;
        end
        if (wrap_dn) begin
            ang_off = q_dn ? (-TWO_PI_E - PI_E) : (q_up ? (PI_E - TWO_PI_E) : -TWO_PI_E);
        end else if (wrap_up) begin
            ang_off = q_dn ? (TWO_PI_E - PI_E) : (q_up ? (TWO_PI_E + PI_E) : TWO_PI_E);
        end else begin
            ang_off = q_dn ? -PI_E : (q_up ? PI_E : '0);
        end
        ang_sum = ang_e + ang_off;
    end

    always_comb begin
        n_stage       = '0;
        n_stage.valid = i_fire;
        n_stage.op    = i_word.operation;
        if (i_word.operation == OP_TO_CART) begin
            n_stage.x  = (q_dn || q_up) ? -r_mag : r_mag;
            n_stage.y  = '0;
            n_stage.z  = ang_sum[Z_W-1:0];
            n_stage.p0 = LEN_W'(i_word.radius_in);
            n_stage.p1 = LEN_W'(i_word.azimuth_in);
        end else begin
            n_stage.zero = (i_word.x_in == '0) && (i_word.y_in == '0);
            // Left half-plane: flip the vector and start from plus or minus pi
            if (i_word.x_in[LEN_W-1]) begin
                n_stage.x = -x_sc;
                n_stage.y = -y_sc;
                n_stage.z = i_word.y_in[LEN_W-1] ? -PI_Q30 : PI_Q30;
            end else begin
                n_stage.x = x_sc;
                n_stage.y = y_sc;
                n_stage.z = '0;
            end
            n_stage.p0 = i_word.x_in;
            n_stage.p1 = i_word.y_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// File: hdl/pcc_cell.sv
module pcc_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  pcc_pkg::t_stage i_stage,
    output pcc_pkg::t_stage o_stage
);
    import pcc_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = pcc_atan(IDX);

    t_stage r_stage;
    t_stage n_stage;

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic                   ccw;

    assign dx = i_stage.y >>> IDX;
    assign dy = i_stage.x >>> IDX;

    // Rotation drives z to zero, vectoring drives y to zero
    assign ccw = (i_stage.op == OP_TO_POLAR) ? i_stage.y[XY_W-1] : !i_stage.z[Z_W-1];

    always_comb begin
        n_stage = i_stage;
        if (ccw) begin
            n_stage.x = i_stage.x - dx;
            n_stage.y = i_stage.y + dy;
            n_stage.z = i_stage.z - ATAN;
        end else begin
            n_stage.x = i_stage.x + dx;
            n_stage.y = i_stage.y - dy;
            n_stage.z = i_stage.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// File: hdl/pcc_post.sv
module pcc_post #(
    parameter int STAGES = pcc_pkg::PCC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  pcc_pkg::t_stage    i_stage,
    output logic               o_valid,
    output pcc_pkg::t_out_word o_word
);
    import pcc_pkg::*;

    localparam logic [63:0] GAIN_ROOT = pcc_gain_root(STAGES);
    localparam logic [63:0] GAIN_Q    = ((64'd1 << 60) + GAIN_ROOT / 64'd2) / GAIN_ROOT;
    localparam logic signed [K_W-1:0] GAIN_K = K_W'(GAIN_Q);

    localparam logic signed [PROD_W-1:0] RND    = PROD_W'(64'd1 << (ROUND_SH - 1));
    localparam logic signed [PROD_W-1:0] XY_HI  = PROD_W'(XY_MAX);
    localparam logic signed [PROD_W-1:0] XY_LO  = PROD_W'(XY_MIN);
    localparam logic signed [PROD_W-1:0] RAD_HI = PROD_W'(RAD_MAX);
    localparam logic signed [Z_W:0]      A_RND  = (Z_W+1)'(1 << (ANG_SHIFT - 1));
    localparam logic signed [Z_W:0]      A_HI   = (Z_W+1)'(ANG_LIM);
    localparam logic signed [Z_W:0]      A_LO   = -A_HI;

    logic                     r_valid;
    logic                     r_op;
    logic                     r_zero;
    logic signed [PROD_W-1:0] r_px;
    logic signed [PROD_W-1:0] r_py;
    logic signed [Z_W-1:0]    r_z;
    logic [LEN_W-1:0]         r_p0;
    logic [LEN_W-1:0]         r_p1;

    logic signed [PROD_W-1:0] n_px;
    logic signed [PROD_W-1:0] n_py;
    logic signed [PROD_W-1:0] sum_x;
    logic signed [PROD_W-1:0] sum_y;
    logic signed [PROD_W-1:0] sx;
    logic signed [PROD_W-1:0] sy;
    logic signed [Z_W:0]      sum_z;
    logic signed [Z_W:0]      sz;

    // Gain correction: one multiplier per axis, registered
    assign n_px = i_stage.x * GAIN_K;
    assign n_py = i_stage.y * GAIN_K;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_stage.valid;
            r_op    <= i_stage.op;
            r_zero  <= i_stage.zero;
            r_px    <= n_px;
            r_py    <= n_py;
            r_z     <= i_stage.z;
            r_p0    <= i_stage.p0;
            r_p1    <= i_stage.p1;
        end
    end

    always_comb begin
        sum_x = r_px + RND;
        sum_y = r_py + RND;
        sx    = sum_x >>> ROUND_SH;
        sy    = sum_y >>> ROUND_SH;
        sum_z = (Z_W+1)'(r_z) + A_RND;
        sz    = sum_z >>> ANG_SHIFT;
        o_word = '0;
        if (r_op == OP_TO_CART) begin
            o_word.x_out       = (sx > XY_HI) ? XY_HI[LEN_W-1:0] :
                                 (sx < XY_LO) ? XY_LO[LEN_W-1:0] : sx[LEN_W-1:0];
            o_word.y_out       = (sy > XY_HI) ? XY_HI[LEN_W-1:0] :
                                 (sy < XY_LO) ? XY_LO[LEN_W-1:0] : sy[LEN_W-1:0];
            o_word.radius_out  = r_p0;
            o_word.azimuth_out = r_p1[ANG_W-1:0];
        end else begin
            o_word.x_out      = r_p0;
            o_word.y_out      = r_p1;
            o_word.radius_out = (sx > RAD_HI) ? RAD_HI[LEN_W-1:0] :
                                sx[PROD_W-1] ? '0 : sx[LEN_W-1:0];
            // Origin has no defined angle: report zero
            if (r_zero) begin
                o_word.azimuth_out = '0;
            end else begin
                o_word.azimuth_out = (sz > A_HI) ? A_HI[ANG_W-1:0] :
                                     (sz < A_LO) ? A_LO[ANG_W-1:0] : sz[ANG_W-1:0];
            end
        end
    end

    assign o_valid = r_valid;

endmodule

// File: hdl/polar_cartesian_converter_core.sv
// Polar/Cartesian converter. Each input word carries an operation bit: 0 turns a radius
// (unsigned, 12 fraction bits) and an azimuth (radians, 16 fraction bits) into x and y,
// 1 turns x and y into radius and atan2 azimuth; the source pair passes through to the
// output unchanged and the origin reports radius 0, azimuth 0. The math runs on a chain
// of CORDIC_STAGES cells (18 by default), one rotation per cell, behind a quadrant
// pre-rotation stage and followed by a gain-correction multiply stage and the
// output register.
// While ready is high one word is accepted every cycle; the chain advances as a unit,
// and a skid register at the output lets the chain hand over one more word while the
// output is held, after which ready drops until the consumer takes the waiting word.
module polar_cartesian_converter_core #(
    parameter int CORDIC_STAGES = pcc_pkg::PCC_STAGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pcc_in_if.sink    i_pt,
    pcc_out_if.source o_pt
);
    import pcc_pkg::*;

    t_stage    chain [0:CORDIC_STAGES];
    t_in_word  in_word;
    t_out_word post_word;
    logic      post_valid;
    logic      adv;
    logic      fire;
    logic      out_take;
    logic      incoming;

    t_out_word r_out;
    logic      r_out_valid;
    t_out_word r_skid;
    logic      r_skid_valid;

    assign adv      = !r_skid_valid;
    assign fire     = i_pt.valid && adv;
    assign out_take = r_out_valid && o_pt.ready;
    assign incoming = adv && post_valid;

    assign in_word.operation  = i_pt.operation;
    assign in_word.radius_in  = i_pt.radius_in;
    assign in_word.azimuth_in = i_pt.azimuth_in;
    assign in_word.x_in       = i_pt.x_in;
    assign in_word.y_in       = i_pt.y_in;

    pcc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_fire  (fire),
        .i_word  (in_word),
        .o_stage (chain[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        pcc_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_stage (chain[g]),
            .o_stage (chain[g+1])
        );
    end

    pcc_post #(
        .STAGES (CORDIC_STAGES)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_stage (chain[CORDIC_STAGES]),
        .o_valid (post_valid),
        .o_word  (post_word)
    );

    // Output register plus skid: park a word when the consumer holds off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (incoming) begin
            if (!r_out_valid || out_take) begin
                r_out       <= post_word;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= post_word;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_pt.ready       = adv;
    assign o_pt.valid       = r_out_valid;
    assign o_pt.x_out       = r_out.x_out;
    assign o_pt.y_out       = r_out.y_out;
    assign o_pt.radius_out  = r_out.radius_out;
    assign o_pt.azimuth_out = r_out.azimuth_out;

endmodule

// File: hdl/pcc_checker.sv
module pcc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic signed [pcc_pkg::LEN_W-1:0] i_x_out,
    input logic signed [pcc_pkg::LEN_W-1:0] i_y_out,
    input logic [pcc_pkg::LEN_W-1:0]        i_radius_out,
    input logic signed [pcc_pkg::ANG_W-1:0] i_azimuth_out
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_x_out) && $stable(i_y_out)
            && $stable(i_radius_out) && $stable(i_azimuth_out))
        else $error("output word changed while stalled");

    // Input back-pressure only comes from a full skid behind a held output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no output word pending");

    a_stall_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready && i_out_ready |=> i_in_ready)
        else $error("input stall not released after output taken");

endmodule

bind polar_cartesian_converter_core pcc_checker u_pcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_pt.ready),
    .i_out_valid   (o_pt.valid),
    .i_out_ready   (o_pt.ready),
    .i_x_out       (o_pt.x_out),
    .i_y_out       (o_pt.y_out),
    .i_radius_out  (o_pt.radius_out),
    .i_azimuth_out (o_pt.azimuth_out)
);

// File: dv/pcc_point_checker.sv
module pcc_point_checker #(
    parameter int STAGES = 18
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pcc_in_if    i_pt,
    pcc_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import pcc_pkg::*;

    localparam longint unsigned ONE62  = 64'd1 << 62;
    localparam longint unsigned HALF32 = 64'd1 << 31;
    localparam longint LEN_LO = -64'sd8388608;
    localparam longint LEN_HI = 64'sd8388607;
    localparam longint RAD_HI = 64'sd16777215;
    localparam longint AZ_HI  = 64'sd411775;

    longint atan_q30 [0:STAGES-1];
    longint pi_q30;
    longint half_pi_q30;
    longint gain_k;

    t_out_word points_due [$];
    t_out_word want;
    t_in_word  seen;

    // atan(1/m), 62 fraction bits, alternating series
    function automatic longint unsigned atan_inv_q62(input longint unsigned m);
        longint unsigned p;
        longint unsigned sum;
        longint unsigned mm;
        longint unsigned t;
        int unsigned     k;
        bit              done;
        p    = m;
        sum  = 0;
        mm   = m * m;
        k    = 0;
        done = 1'b0;
        while (!done) begin
            t = (ONE62 / p) / (2 * k + 1);
            if (k[0]) sum -= t;
            else      sum += t;
            k++;
            if (p > ONE62 / mm) done = 1'b1;
            else                p = p * mm;
        end
        return sum;
    endfunction

    // atan(2^-i), 62 fraction bits, i >= 1
    function automatic longint unsigned atan_pow2_q62(input int unsigned i);
        longint unsigned sum;
        longint unsigned t;
        int unsigned     k;
        sum = 0;
        k   = 0;
        while (i * (2 * k + 1) <= 62) begin
            t = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
            if (k[0]) sum -= t;
            else      sum += t;
            k++;
        end
        return sum;
    endfunction

    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // undo the CORDIC gain and drop the guard bits, rounding half up
    function automatic longint gain_fix(input longint v);
        return (v * gain_k + (longint'(1) <<< 35)) >>> 36;
    endfunction

    function automatic t_out_word convert_point(input t_in_word w);
        t_out_word res;
        longint    x;
        longint    y;
        longint    a;
        longint    dx;
        longint    dy;
        longint    v;
        x = 0;
        y = 0;
        a = 0;
        if (w.operation == OP_TO_CART) begin
            x = longint'(w.radius_in) * 64;
            a = $signed(w.azimuth_in);
            a = a * 16384;
            while (a > pi_q30)  a -= 2 * pi_q30;
            while (a < -pi_q30) a += 2 * pi_q30;
            // fold the back half-plane onto the front one
            if (a > half_pi_q30) begin
                x = -x;
                a -= pi_q30;
            end else if (a < -half_pi_q30) begin
                x = -x;
                a += pi_q30;
            end
            for (int i = 0; i < STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (a >= 0) begin
                    x -= dx; y += dy; a -= atan_q30[i];
                end else begin
                    x += dx; y -= dy; a += atan_q30[i];
                end
            end
            v = clip(gain_fix(x), LEN_LO, LEN_HI);
            res.x_out = v[23:0];
            v = clip(gain_fix(y), LEN_LO, LEN_HI);
            res.y_out = v[23:0];
            res.radius_out  = {1'b0, w.radius_in};
            res.azimuth_out = w.azimuth_in;
        end else begin
            res.x_out = w.x_in;
            res.y_out = w.y_in;
            if (w.x_in == 0 && w.y_in == 0) begin
                res.radius_out  = '0;
                res.azimuth_out = '0;
            end else begin
                x = $signed(w.x_in);
                y = $signed(w.y_in);
                x = x * 64;
                y = y * 64;
                if (x < 0) begin
                    a = (y >= 0) ? pi_q30 : -pi_q30;
                    x = -x;
                    y = -y;
                end
                for (int i = 0; i < STAGES; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (y >= 0) begin
                        x += dx; y -= dy; a += atan_q30[i];
                    end else begin
                        x -= dx; y += dy; a -= atan_q30[i];
                    end
                end
                v = clip(gain_fix(x), 0, RAD_HI);
                res.radius_out = v[23:0];
                v = clip((a + 8192) >>> 14, -AZ_HI, AZ_HI);
                res.azimuth_out = v[19:0];
            end
        end
        return res;
    endfunction

    initial begin
        longint unsigned q4;
        longint unsigned g;
        longint unsigned root;
        q4 = 64'd4 * atan_inv_q62(5) - atan_inv_q62(239);
        atan_q30[0] = longint'((q4 + HALF32) >> 32);
        for (int i = 1; i < STAGES; i++)
            atan_q30[i] = longint'((atan_pow2_q62(i) + HALF32) >> 32);
        pi_q30      = longint'((64'd4 * q4 + HALF32) >> 32);
        half_pi_q30 = longint'((64'd2 * q4 + HALF32) >> 32);
        g = 64'd1 << 60;
        for (int i = 0; i < STAGES; i++)
            g = g + (g >> (2 * i));
        root   = isqrt64(g);
        gain_k = longint'(((64'd1 << 60) + root / 2) / root);
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pt.valid && i_pt.ready) begin
                seen.operation  = i_pt.operation;
                seen.radius_in  = i_pt.radius_in;
                seen.azimuth_in = i_pt.azimuth_in;
                seen.x_in       = i_pt.x_in;
                seen.y_in       = i_pt.y_in;
                points_due.push_back(convert_point(seen));
            end
            if (i_res.valid && i_res.ready) begin
                if (points_due.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    o_fail_count++;
                end else begin
                    want = points_due.pop_front();
                    if (i_res.x_out !== want.x_out) begin
                        $error("x_out: expected %0d, actual %0d", want.x_out, i_res.x_out);
                        o_fail_count++;
                    end
                    if (i_res.y_out !== want.y_out) begin
                        $error("y_out: expected %0d, actual %0d", want.y_out, i_res.y_out);
                        o_fail_count++;
                    end
                    if (i_res.radius_out !== want.radius_out) begin
                        $error("radius_out: expected %0d, actual %0d",
                               want.radius_out, i_res.radius_out);
                        o_fail_count++;
                    end
                    if (i_res.azimuth_out !== want.azimuth_out) begin
                        $error("azimuth_out: expected %0d, actual %0d",
                               want.azimuth_out, i_res.azimuth_out);
                        o_fail_count++;
                    end
                end
            end
            o_pending = points_due.size();
        end
    end

endmodule

// File: dv/polar_cartesian_converter_core_tb.sv
module polar_cartesian_converter_core_tb;
    import pcc_pkg::*;

    localparam int STAGES      = 18;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = STAGES + 3 + 20;
    localparam int RANDOM_ITEMS = 650;

    // angles in the 16-fraction-bit format
    localparam int AZ_PI      = 205887;
    localparam int AZ_HALF_PI = 102944;
    localparam int AZ_LIM     = 411775;
    localparam int LEN_MAX    = 8388607;
    localparam int LEN_MIN    = -8388608;
    localparam int RAD_MAX_IN = 8388607;
    localparam int AZ_RAW_MIN = -524288;
    localparam int AZ_RAW_MAX = 524287;

    logic i_clk;
    logic i_rst_n = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   fail_count;
    int   pending;
    int   cycle_count;

    pcc_in_if  pt_in ();
    pcc_out_if pt_out ();

    polar_cartesian_converter_core #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_in),
        .o_pt   (pt_out)
    );

    pcc_point_checker #(
        .STAGES(STAGES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pt        (pt_in),
        .i_res       (pt_out),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        pt_in.valid      = 1'b0;
        pt_in.operation  = OP_TO_CART;
        pt_in.radius_in  = '0;
        pt_in.azimuth_in = '0;
        pt_in.x_in       = '0;
        pt_in.y_in       = '0;
        pt_out.ready     = 1'b0;
    end

    // consumer back-pressure
    always @(negedge i_clk) begin
        pt_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_word(input logic op, input int rad, input int az,
                             input int px, input int py);
        while ($urandom_range(99) < send_idle_pct) begin
            pt_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt_in.valid      <= 1'b1;
        pt_in.operation  <= op;
        pt_in.radius_in  <= RAD_IN_W'(rad);
        pt_in.azimuth_in <= ANG_W'(az);
        pt_in.x_in       <= LEN_W'(px);
        pt_in.y_in       <= LEN_W'(py);
        do @(posedge i_clk); while (!pt_in.ready);
        @(negedge i_clk);
    endtask

    // hold off until every word in flight has come out
    task automatic drain();
        pt_in.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic send_random();
        logic op;
        int   rad;
        int   az;
        int   px;
        int   py;
        int   pick;
        op = ($urandom_range(1) == 1) ? OP_TO_POLAR : OP_TO_CART;
        rad = ($urandom_range(9) < 7) ? int'($urandom_range(RAD_MAX_IN))
                                      : int'($urandom_range(4096));
        pick = $urandom_range(9);
        if (pick < 8)
            az = int'($urandom_range(2 * AZ_LIM)) - AZ_LIM;
        else if (pick == 8)
            az = ($urandom_range(1) ? AZ_PI : AZ_HALF_PI) * ($urandom_range(1) ? 1 : -1)
                 + int'($urandom_range(4)) - 2;
        else
            az = int'($urandom);
        pick = $urandom_range(9);
        if (pick < 6) begin
            px = int'($urandom);
            py = int'($urandom);
        end else if (pick < 9) begin
            px = int'($urandom_range(8192)) - 4096;
            py = int'($urandom_range(8192)) - 4096;
        end else begin
            px = $urandom_range(1) ? 0 : ($urandom_range(1) ? LEN_MAX : LEN_MIN);
            py = $urandom_range(1) ? 0 : ($urandom_range(1) ? LEN_MAX : LEN_MIN);
        end
        send_word(op, rad, az, px, py);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // rotation: extremes, quadrant folds, wrap beyond pi, any 20-bit pattern
        send_word(OP_TO_CART, 0, 0, $urandom, $urandom);
        send_word(OP_TO_CART, RAD_MAX_IN, 0, $urandom, $urandom);
        send_word(OP_TO_CART, RAD_MAX_IN, AZ_LIM, $urandom, $urandom);
        send_word(OP_TO_CART, RAD_MAX_IN, -AZ_LIM, $urandom, $urandom);
        send_word(OP_TO_CART, 4096, AZ_HALF_PI - 1, 0, -1);
        send_word(OP_TO_CART, 4096, AZ_HALF_PI, -1, 0);
        send_word(OP_TO_CART, 4096, -AZ_HALF_PI, $urandom, $urandom);
        send_word(OP_TO_CART, 4096, AZ_PI, $urandom, $urandom);
        send_word(OP_TO_CART, 4096, AZ_PI + 1, $urandom, $urandom);
        send_word(OP_TO_CART, 4096, -AZ_PI - 1, $urandom, $urandom);
        send_word(OP_TO_CART, RAD_MAX_IN, AZ_RAW_MIN, $urandom, $urandom);
        send_word(OP_TO_CART, RAD_MAX_IN, AZ_RAW_MAX, $urandom, $urandom);
        send_word(OP_TO_CART, 1, 12345, $urandom, $urandom);
        // vectoring: origin, extremes, negative x on either side of the axis
        send_word(OP_TO_POLAR, $urandom, $urandom, 0, 0);
        send_word(OP_TO_POLAR, $urandom, $urandom, LEN_MAX, LEN_MAX);
        send_word(OP_TO_POLAR, $urandom, $urandom, LEN_MIN, LEN_MIN);
        send_word(OP_TO_POLAR, $urandom, $urandom, LEN_MIN, 0);
        send_word(OP_TO_POLAR, $urandom, $urandom, -4096, -1);
        send_word(OP_TO_POLAR, $urandom, $urandom, 0, LEN_MAX);
        send_word(OP_TO_POLAR, $urandom, $urandom, 0, LEN_MIN);
        send_word(OP_TO_POLAR, $urandom, $urandom, LEN_MAX, 0);
        send_word(OP_TO_POLAR, $urandom, $urandom, -1, 0);
        send_word(OP_TO_POLAR, $urandom, $urandom, 1, 1);
        send_word(OP_TO_POLAR, $urandom, $urandom, LEN_MAX, LEN_MIN);
        drain();

        send_idle_pct  = 36;
        recv_stall_pct = 73;
        repeat (RANDOM_ITEMS / 3) send_random();
        send_idle_pct  = 73;
        recv_stall_pct = 36;
        repeat (RANDOM_ITEMS / 3) send_random();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3)) send_random();

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/pcc_pkg.sv
hdl/pcc_in_if.sv
hdl/pcc_out_if.sv
hdl/pcc_prep.sv
hdl/pcc_cell.sv
hdl/pcc_post.sv
hdl/polar_cartesian_converter_core.sv
hdl/pcc_checker.sv
dv/pcc_point_checker.sv
dv/polar_cartesian_converter_core_tb.sv
